/* hdl/owts_pkg.sv */
// Shared types, codes and tables for the one-wire temperature sensor master.
// No dependencies; used by every module of the block but owts_checker.
`default_nettype none
package owts_pkg;

   localparam int LINE_COUNT_DEF = 4;

   // word kinds on the request channel
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // sequence steps
   localparam logic [3:0] STEP_CONV_RESET = 4'd0;
   localparam logic [3:0] STEP_CONV_SKIP  = 4'd1;
   localparam logic [3:0] STEP_CONV_CMD   = 4'd2;
   localparam logic [3:0] STEP_PROBE      = 4'd3;
   localparam logic [3:0] STEP_RD_RESET   = 4'd4;
   localparam logic [3:0] STEP_RD_SKIP    = 4'd5;
   localparam logic [3:0] STEP_RD_CMD     = 4'd6;
   localparam logic [3:0] STEP_RD_LOW     = 4'd7;
   localparam logic [3:0] STEP_RD_HIGH    = 4'd8;
   localparam logic [3:0] STEP_RD_END     = 4'd9;
   localparam logic [3:0] STEP_IDLE       = 4'd15;

   // slot types
   localparam logic [1:0] TYPE_RESET = 2'd0;
   localparam logic [1:0] TYPE_WRITE = 2'd1;
   localparam logic [1:0] TYPE_PROBE = 2'd2;
   localparam logic [1:0] TYPE_RBYTE = 2'd3;

   // phases within a slot
   localparam logic [1:0] SUB_LEAD = 2'd0;
   localparam logic [1:0] SUB_MID  = 2'd1;
   localparam logic [1:0] SUB_TAIL = 2'd2;

   localparam logic [7:0] CMD_SKIP_ROM  = 8'hcc;
   localparam logic [7:0] CMD_CONVERT   = 8'h44;
   localparam logic [7:0] CMD_READ_SPAD = 8'hbe;

   localparam logic [2:0] LAST_BIT = 3'd7;

   typedef struct packed {
      logic [3:0]  pull_lines;
      logic        busy_res;
      logic        result_valid;
      logic        not_ready;
      logic [16:0] temperature_milli;
   } result_type;

   function automatic logic [1:0] step_type(input logic [3:0] step);
      logic [1:0] t;
      unique case (step) inside
         STEP_CONV_RESET, STEP_RD_RESET, STEP_RD_END: t = TYPE_RESET;
         STEP_CONV_SKIP, STEP_CONV_CMD, STEP_RD_SKIP, STEP_RD_CMD: t = TYPE_WRITE;
         STEP_PROBE: t = TYPE_PROBE;
         STEP_RD_LOW, STEP_RD_HIGH: t = TYPE_RBYTE;
         default: t = TYPE_RESET;
      endcase
      return t;
   endfunction

   function automatic logic [7:0] step_byte(input logic [3:0] step);
      logic [7:0] b;
      unique case (step) inside
         STEP_CONV_SKIP, STEP_RD_SKIP: b = CMD_SKIP_ROM;
         STEP_CONV_CMD: b = CMD_CONVERT;
         STEP_RD_CMD: b = CMD_READ_SPAD;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // phase lengths in microsecond ticks
   function automatic logic [8:0] sub_len(input logic [1:0] t, input logic [1:0] sub);
      logic [8:0] n;
      if (t == TYPE_RESET) begin
         case (sub)
            SUB_LEAD: n = 9'd480;
            SUB_MID:  n = 9'd60;
            default:  n = 9'd420;
         endcase
      end else if (t == TYPE_WRITE) begin
         n = (sub == SUB_MID) ? 9'd60 : 9'd1;
      end else begin
         case (sub)
            SUB_LEAD: n = 9'd1;
            SUB_MID:  n = 9'd14;
            default:  n = 9'd45;
         endcase
      end
      return n;
   endfunction

   // sixteenths of a degree to thousandths, truncated
   function automatic logic [9:0] frac_milli(input logic [3:0] f);
      logic [9:0] m;
      case (f)
         4'd0:  m = 10'd0;
         4'd1:  m = 10'd62;
         4'd2:  m = 10'd125;
         4'd3:  m = 10'd187;
         4'd4:  m = 10'd250;
         4'd5:  m = 10'd312;
         4'd6:  m = 10'd375;
         4'd7:  m = 10'd437;
         4'd8:  m = 10'd500;
         4'd9:  m = 10'd562;
         4'd10: m = 10'd625;
         4'd11: m = 10'd687;
         4'd12: m = 10'd750;
         4'd13: m = 10'd812;
         4'd14: m = 10'd875;
         default: m = 10'd937;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

/* hdl/one_wire_temp_sensor_master.sv */
// One-wire temperature sensor master, top level.
// Depends on owts_pkg, owts_seq and owts_out.
//
// Each request word is a one-microsecond tick with sampled line levels, or a
// start or read command; each produces exactly one response word, registered
// in the response output register. One word is taken every cycle, limited
// only by that register: req_stall rises only while a held response is
// stalled. The sequencer state advances once per accepted word, so slot
// timing follows the tick words as delivered.
`default_nettype none
module one_wire_temp_sensor_master
   import owts_pkg::*;
#(
   parameter int LINE_COUNT = LINE_COUNT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [1:0]  req_bus,
   input  wire logic [3:0]  req_line_levels,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_pull_lines,
   output logic             rsp_busy_res,
   output logic             rsp_result_valid,
   output logic             rsp_not_ready,
   output logic [16:0]      rsp_temperature_milli
);

   logic       ready;
   logic       accept;
   result_type seq_result;
   result_type rsp_word;

   assign req_stall = !ready;
   assign accept    = req_valid && ready;

   owts_seq #(
      .LINE_COUNT(LINE_COUNT)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .kind        (req_kind),
      .bus         (req_bus),
      .line_levels (req_line_levels),
      .result      (seq_result)
   );

   owts_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .data_in   (seq_result),
      .out_stall (rsp_stall),
      .ready     (ready),
      .out_valid (rsp_valid),
      .data_out  (rsp_word)
   );

   assign rsp_pull_lines        = rsp_word.pull_lines;
   assign rsp_busy_res          = rsp_word.busy_res;
   assign rsp_result_valid      = rsp_word.result_valid;
   assign rsp_not_ready         = rsp_word.not_ready;
   assign rsp_temperature_milli = rsp_word.temperature_milli;

endmodule
`default_nettype wire

/* hdl/owts_seq.sv */
// Bus sequencer: slot timing, bit shifting and temperature conversion.
// Depends on owts_pkg. Updates its state on every accepted word.
`default_nettype none
module owts_seq
   import owts_pkg::*;
#(
   parameter int LINE_COUNT = LINE_COUNT_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [1:0] kind,
   input  wire logic [1:0] bus,
   input  wire logic [3:0] line_levels,
   output result_type      result
);

   logic [3:0] step_ff, step_in;
   logic [1:0] sub_ff, sub_in;
   logic [8:0] timer_ff, timer_in;
   logic [2:0] bitcnt_ff, bitcnt_in;
   logic [7:0] shift_ff, shift_in;
   logic [1:0] active_ff, active_in;
   logic [7:0] low_ff, low_in;
   logic [7:0] high_ff, high_in;

   logic [1:0]  cur_type;
   logic [8:0]  timer_inc;
   logic        idle;
   logic        done;
   logic        drive;
   logic        busy;
   logic [3:0]  pull;
   logic        res_valid;
   logic        res_nrdy;
   logic [16:0] res_milli;
   logic [6:0]  whole;
   logic [16:0] milli;

   assign idle     = (step_ff == STEP_IDLE);
   assign cur_type = step_type(step_ff);
   assign timer_inc = timer_ff + 9'd1;
   assign whole    = {high_ff[2:0], low_ff[7:4]};
   assign milli    = 17'(whole) * 17'd1000 + 17'(frac_milli(low_ff[3:0]));

   always_comb begin
      step_in   = step_ff;
      sub_in    = sub_ff;
      timer_in  = timer_ff;
      bitcnt_in = bitcnt_ff;
      shift_in  = shift_ff;
      active_in = active_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      done      = 1'b0;
      res_valid = 1'b0;
      res_nrdy  = 1'b0;
      res_milli = '0;

      if ((kind == KIND_START || kind == KIND_READ)) begin
         if (idle && (32'(bus) < LINE_COUNT)) begin
            active_in = bus;
            step_in   = (kind == KIND_READ) ? STEP_PROBE : STEP_CONV_RESET;
            sub_in    = SUB_LEAD;
            timer_in  = '0;
            bitcnt_in = '0;
            shift_in  = step_byte(step_in);
         end
      end else if (kind == KIND_TICK && !idle) begin
         if (timer_inc >= sub_len(cur_type, sub_ff)) begin
            timer_in = '0;
            if (sub_ff != SUB_TAIL) begin
               if ((cur_type == TYPE_PROBE || cur_type == TYPE_RBYTE) && sub_ff == SUB_MID)
                  shift_in = {line_levels[active_ff], shift_ff[7:1]};
               sub_in = sub_ff + 2'd1;
            end else begin
               done = 1'b1;
               if (cur_type == TYPE_WRITE || cur_type == TYPE_RBYTE) begin
                  if (cur_type == TYPE_WRITE)
                     shift_in = {1'b0, shift_ff[7:1]};
                  if (bitcnt_ff < LAST_BIT) begin
                     bitcnt_in = bitcnt_ff + 3'd1;
                     sub_in    = SUB_LEAD;
                     done      = 1'b0;
                  end
               end
               if (done) begin
                  unique case (step_ff)
                     STEP_CONV_CMD: begin
                        step_in = STEP_IDLE;
                     end
                     STEP_PROBE: begin
                        if (!shift_in[7]) begin
                           step_in   = STEP_IDLE;
                           res_valid = 1'b1;
                           res_nrdy  = 1'b1;
                        end else begin
                           step_in   = STEP_RD_RESET;
                           sub_in    = SUB_LEAD;
                           bitcnt_in = '0;
                           shift_in  = step_byte(STEP_RD_RESET);
                        end
                     end
                     STEP_RD_END: begin
                        step_in   = STEP_IDLE;
                        res_valid = 1'b1;
                        res_milli = milli;
                     end
                     default: begin
                        if (step_ff == STEP_RD_LOW)
                           low_in = shift_in;
                        else if (step_ff == STEP_RD_HIGH)
                           high_in = shift_in;
                        step_in   = step_ff + 4'd1;
                        sub_in    = SUB_LEAD;
                        bitcnt_in = '0;
                        shift_in  = step_byte(step_in);
                     end
                  endcase
               end
            end
         end else begin
            timer_in = timer_inc;
         end
      end
   end

   // line drive as seen after this word
   always_comb begin
      drive = (sub_in == SUB_LEAD) ||
              (step_type(step_in) == TYPE_WRITE && sub_in == SUB_MID && !shift_in[0]);
      busy  = (step_in != STEP_IDLE);
      pull  = (busy && drive) ? (4'b0001 << active_in) : 4'b0000;
   end

   assign result = '{pull, busy, res_valid, res_nrdy, res_milli};

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_IDLE;
         sub_ff    <= SUB_LEAD;
         timer_ff  <= '0;
         bitcnt_ff <= '0;
         shift_ff  <= '0;
         active_ff <= '0;
      end else if (accept) begin
         step_ff   <= step_in;
         sub_ff    <= sub_in;
         timer_ff  <= timer_in;
         bitcnt_ff <= bitcnt_in;
         shift_ff  <= shift_in;
         active_ff <= active_in;
      end
   end

   // scratchpad bytes, written before use
   always_ff @(posedge clock) begin
      if (accept) begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/owts_out.sv */
// Output register for the response channel; frees the request side whenever
// it is empty or the held word is being taken. Depends on owts_pkg.
`default_nettype none
module owts_out
   import owts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire result_type data_in,
   input  wire logic       out_stall,
   output logic            ready,
   output logic            out_valid,
   output result_type      data_out
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign ready     = !valid_ff || !out_stall;
   assign valid_in  = load ? 1'b1 : (valid_ff && out_stall);
   assign out_valid = valid_ff;
   assign data_out  = data_ff;

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load)
         data_ff <= data_in;
   end

endmodule
`default_nettype wire

/* hdl/owts_checker.sv */
// Port-level checks for the one-wire temperature sensor master,
// bound to the top level. No package dependency.
`default_nettype none
module owts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_kind,
   input wire logic [1:0]  req_bus,
   input wire logic [3:0]  req_line_levels,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [3:0]  rsp_pull_lines,
   input wire logic        rsp_busy_res,
   input wire logic        rsp_result_valid,
   input wire logic        rsp_not_ready,
   input wire logic [16:0] rsp_temperature_milli
);

   // held word stays put: valid, temperature, pull lines and result flag
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_temperature_milli)
         && $stable(rsp_pull_lines) && $stable(rsp_result_valid))
      else $error("stalled response word changed");

   // a finished read leaves the bus released and idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_valid |-> !rsp_busy_res && rsp_pull_lines == 4'b0000)
      else $error("result reported while sequence still running");

   a_not_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_not_ready |-> rsp_result_valid && rsp_temperature_milli == 17'd0)
      else $error("not_ready without result_valid or with a temperature");

   a_one_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_pull_lines) && (rsp_busy_res || rsp_pull_lines == 4'b0000))
      else $error("line drive outside a sequence or on several lines");

   // a word is taken whenever the output side is free
   a_take: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output register");

endmodule

bind one_wire_temp_sensor_master owts_checker u_checker (.*);
`default_nettype wire

/* sim/one_wire_temp_sensor_master_tb.sv */
`timescale 1ns / 100ps
// Testbench for one_wire_temp_sensor_master: a directed table of words, then
// random start/read sequences, each response word checked against a local model
// or a hand-written value. Depends on owts_pkg and the block's RTL.
module one_wire_temp_sensor_master_tb;
   import owts_pkg::*;

   localparam logic [1:0] KIND_NONE = 2'd3;   // unused kind code, ignored by the block

   typedef struct {
      logic [1:0] kind;
      logic [1:0] bus;
      logic [3:0] levels;
      int         reps;
      bit         typed;      // last word of the row carries a hand-written response
      result_type want;
   } stim_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = KIND_TICK;
   logic [1:0]  req_bus = 2'd0;
   logic [3:0]  req_line_levels = 4'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_pull_lines;
   logic        rsp_busy_res;
   logic        rsp_result_valid;
   logic        rsp_not_ready;
   logic [16:0] rsp_temperature_milli;

   // model of the sequencer
   logic [3:0] seq_step = STEP_IDLE;
   logic [1:0] seq_sub = SUB_LEAD;
   logic [1:0] seq_bus = 2'd0;
   logic [8:0] seq_timer = 9'd0;
   logic [2:0] seq_bit = 3'd0;
   logic [7:0] seq_shift = 8'd0;
   logic [7:0] temp_lo = 8'd0;
   logic [7:0] temp_hi = 8'd0;

   result_type   rsp_due[$];
   stim_row_type stim_rows[$];
   int           fails = 0;
   int           calm_words = 0;
   bit           long_hold_req = 1'b0;

   one_wire_temp_sensor_master u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_kind              (req_kind),
      .req_bus               (req_bus),
      .req_line_levels       (req_line_levels),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_pull_lines        (rsp_pull_lines),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_result_valid      (rsp_result_valid),
      .rsp_not_ready         (rsp_not_ready),
      .rsp_temperature_milli (rsp_temperature_milli)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [1:0] slot_of(input logic [3:0] step);
      case (step)
         STEP_CONV_SKIP, STEP_CONV_CMD, STEP_RD_SKIP, STEP_RD_CMD: return TYPE_WRITE;
         STEP_PROBE: return TYPE_PROBE;
         STEP_RD_LOW, STEP_RD_HIGH: return TYPE_RBYTE;
         default: return TYPE_RESET;
      endcase
   endfunction

   function automatic int ticks_of(input logic [1:0] slot, input logic [1:0] sub);
      case (slot)
         TYPE_RESET: return (sub == SUB_LEAD) ? 480 : (sub == SUB_MID) ? 60 : 420;
         TYPE_WRITE: return (sub == SUB_MID) ? 60 : 1;
         default:    return (sub == SUB_LEAD) ? 1 : (sub == SUB_MID) ? 14 : 45;
      endcase
   endfunction

   task automatic enter_step(input logic [3:0] step);
      seq_step = step;
      seq_sub = SUB_LEAD;
      seq_timer = 9'd0;
      seq_bit = 3'd0;
      case (step)
         STEP_CONV_SKIP, STEP_RD_SKIP: seq_shift = CMD_SKIP_ROM;
         STEP_CONV_CMD: seq_shift = CMD_CONVERT;
         STEP_RD_CMD: seq_shift = CMD_READ_SPAD;
         default: seq_shift = 8'h00;
      endcase
   endtask

   // advances the sequencer by one accepted word and returns its response word
   task automatic master_step(input logic [1:0] kind, input logic [1:0] bus,
                              input logic [3:0] levels, output result_type r);
      logic [1:0] slot;
      bit         fin;
      int         whole;
      r = '0;
      if (kind == KIND_START || kind == KIND_READ) begin
         if (seq_step == STEP_IDLE && int'(bus) < LINE_COUNT_DEF) begin
            seq_bus = bus;
            enter_step((kind == KIND_READ) ? STEP_PROBE : STEP_CONV_RESET);
         end
      end else if (kind == KIND_TICK && seq_step != STEP_IDLE) begin
         slot = slot_of(seq_step);
         seq_timer = seq_timer + 9'd1;
         if (int'(seq_timer) >= ticks_of(slot, seq_sub)) begin
            seq_timer = 9'd0;
            if (seq_sub != SUB_TAIL) begin
               if ((slot == TYPE_PROBE || slot == TYPE_RBYTE) && seq_sub == SUB_MID)
                  seq_shift = {levels[seq_bus], seq_shift[7:1]};
               seq_sub = seq_sub + 2'd1;
            end else begin
               fin = 1'b1;
               if (slot == TYPE_WRITE || slot == TYPE_RBYTE) begin
                  if (slot == TYPE_WRITE)
                     seq_shift = seq_shift >> 1;
                  if (seq_bit < LAST_BIT) begin
                     seq_bit = seq_bit + 3'd1;
                     seq_sub = SUB_LEAD;
                     fin = 1'b0;
                  end
               end
               if (fin) begin
                  case (seq_step)
                     STEP_CONV_CMD: seq_step = STEP_IDLE;
                     STEP_PROBE: begin
                        if (!seq_shift[7]) begin
                           seq_step = STEP_IDLE;
                           r.result_valid = 1'b1;
                           r.not_ready = 1'b1;
                        end else begin
                           enter_step(STEP_RD_RESET);
                        end
                     end
                     STEP_RD_END: begin
                        seq_step = STEP_IDLE;
                        r.result_valid = 1'b1;
                        whole = int'({temp_hi[2:0], temp_lo[7:4]});
                        r.temperature_milli = 17'(whole * 1000 + int'(temp_lo[3:0]) * 625 / 10);
                     end
                     default: begin
                        if (seq_step == STEP_RD_LOW)
                           temp_lo = seq_shift;
                        else if (seq_step == STEP_RD_HIGH)
                           temp_hi = seq_shift;
                        enter_step(seq_step + 4'd1);
                     end
                  endcase
               end
            end
         end
      end
      if (seq_step != STEP_IDLE) begin
         r.busy_res = 1'b1;
         if (seq_sub == SUB_LEAD ||
             (slot_of(seq_step) == TYPE_WRITE && seq_sub == SUB_MID && !seq_shift[0]))
            r.pull_lines = 4'b0001 << seq_bus;
      end
   endtask

   // idle cycles before the next word: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (calm_words > 0) begin
         calm_words--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_words = $urandom_range(100, 400);
         return 0;
      end
      if (r < 68) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_word(input logic [1:0] kind, input logic [1:0] bus,
                            input logic [3:0] levels, input bit typed,
                            input result_type want);
      int         gap;
      result_type p;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_bus <= bus;
      req_line_levels <= levels;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      master_step(kind, bus, levels, p);
      rsp_due.push_back(typed ? want : p);
   endtask

   task automatic send_any();
      send_word(2'($urandom), 2'($urandom), 4'($urandom), 1'b0, '0);
   endtask

   // sender holds off until every outstanding response word is back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rsp_due.size() != 0) @(negedge clock);
   endtask

   task automatic add_row(input logic [1:0] kind, input logic [1:0] bus,
                          input logic [3:0] levels, input int reps, input bit typed,
                          input logic [3:0] pull, input logic busy, input logic done,
                          input logic nrdy, input logic [16:0] milli);
      stim_row_type row;
      row.kind = kind;
      row.bus = bus;
      row.levels = levels;
      row.reps = reps;
      row.typed = typed;
      row.want = '{pull, busy, done, nrdy, milli};
      stim_rows.push_back(row);
   endtask

   function automatic void note_field(input string name, input int want, input int got);
      if (want != got) begin
         fails++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_due.size() == 0) begin
            fails++;
            $display("%0t: response word with none outstanding", $time);
         end else begin
            want = rsp_due.pop_front();
            note_field("pull_lines", want.pull_lines, rsp_pull_lines);
            note_field("busy_res", want.busy_res, rsp_busy_res);
            note_field("result_valid", want.result_valid, rsp_result_valid);
            note_field("not_ready", want.not_ready, rsp_not_ready);
            note_field("temperature_milli", want.temperature_milli, rsp_temperature_milli);
         end
      end
   end

   // response side: random stall runs, plus one long hold-off on request
   initial begin : rsp_side
      int len;
      bit hold;
      forever begin
         if (long_hold_req) begin
            hold = 1'b1;
            len = 400;
            long_hold_req = 1'b0;
         end else if ($urandom_range(0, 1) == 0) begin
            hold = 1'b0;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
         end else begin
            hold = 1'b1;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         end
         @(negedge clock);
         rsp_stall <= hold;
         repeat (len - 1) @(negedge clock);
      end
   end

   initial begin : stimulus
      int r;
      int n;
      int seq_n;
      int rnd_words;
      stim_row_type row;

      //      kind        bus    lev    reps  typ  pull     busy done nrdy milli
      add_row(KIND_TICK,  2'd0, 4'hf,     3, 1, 4'b0000, 0, 0, 0, 17'd0);
      add_row(KIND_NONE,  2'd2, 4'h0,     1, 1, 4'b0000, 0, 0, 0, 17'd0);
      add_row(KIND_START, 2'd0, 4'h0,     1, 1, 4'b0001, 1, 0, 0, 17'd0);
      add_row(KIND_READ,  2'd1, 4'h0,     1, 0, 4'b0000, 0, 0, 0, 17'd0);
      add_row(KIND_TICK,  2'd0, 4'hf,  1952, 1, 4'b0000, 0, 0, 0, 17'd0);
      add_row(KIND_READ,  2'd1, 4'h0,     1, 1, 4'b0010, 1, 0, 0, 17'd0);
      add_row(KIND_TICK,  2'd0, 4'h0,    60, 1, 4'b0000, 0, 1, 1, 17'd0);
      add_row(KIND_READ,  2'd2, 4'h0,     1, 1, 4'b0100, 1, 0, 0, 17'd0);
      add_row(KIND_TICK,  2'd0, 4'hf,  3932, 1, 4'b0000, 0, 1, 0, 17'd127937);
      add_row(KIND_READ,  2'd3, 4'h0,     1, 1, 4'b1000, 1, 0, 0, 17'd0);
      add_row(KIND_TICK,  2'd0, 4'hf,    60, 0, 4'b0000, 0, 0, 0, 17'd0);
      add_row(KIND_START, 2'd0, 4'h0,     1, 0, 4'b0000, 0, 0, 0, 17'd0);
      add_row(KIND_NONE,  2'd1, 4'h5,     1, 0, 4'b0000, 0, 0, 0, 17'd0);
      add_row(KIND_TICK,  2'd0, 4'h0,  3872, 1, 4'b0000, 0, 1, 0, 17'd0);
      add_row(KIND_START, 2'd3, 4'h0,     1, 1, 4'b1000, 1, 0, 0, 17'd0);
      add_row(KIND_TICK,  2'd0, 4'h5,  1952, 0, 4'b0000, 0, 0, 0, 17'd0);
      add_row(KIND_READ,  2'd0, 4'h0,     1, 1, 4'b0001, 1, 0, 0, 17'd0);
      add_row(KIND_TICK,  2'd0, 4'he,    60, 1, 4'b0000, 0, 1, 1, 17'd0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         for (int k = 0; k < row.reps; k++)
            send_word(row.kind, row.bus, row.levels, row.typed && k == row.reps - 1, row.want);
      end
      wait_drained();

      // random part: well-formed command sequences with random line levels,
      // broken up by noise bursts and stray commands while busy
      seq_n = 0;
      rnd_words = 0;
      while (rnd_words < 1100 && seq_n < 60) begin
         seq_n++;
         if (seq_n == 1)
            long_hold_req = 1'b1;
         if (seq_n == 12)
            wait_drained();
         r = $urandom_range(0, 99);
         if (r < 12) begin
            n = $urandom_range(1, 12);
            repeat (n) send_any();
            rnd_words += n;
         end else begin
            send_word((r < 40) ? KIND_START : KIND_READ, 2'($urandom), 4'($urandom), 1'b0, '0);
            rnd_words++;
            while (seq_step != STEP_IDLE && rnd_words < 1100) begin
               if ($urandom_range(0, 299) == 0) begin
                  send_any();
               end else begin
                  send_word(KIND_TICK, 2'($urandom), 4'($urandom), 1'b0, '0);
                  rnd_words++;
               end
            end
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (fails == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
